@@ src/hamming_encode_check_unit_defines.svh @@
// Assertion macros used by the top-level unit to check this block.
`ifndef HAMMING_ENCODE_CHECK_UNIT_DEFINES_SVH
`define HAMMING_ENCODE_CHECK_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define HEC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define HEC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hec_pkg.sv @@
package hec_pkg;

    // Field widths
    localparam int DATA_W = 57;
    localparam int CODE_W = 63;
    localparam int SYN_W  = 6;
    localparam int CFG_W  = 6;

    // Register reset and default limits
    localparam int DATA_BITS_RESET       = 4;
    localparam int MAX_CODE_BITS_DEFAULT = 63;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] data_word;
        logic [CODE_W-1:0] code_word;
    } hec_req_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic [SYN_W-1:0]  syndrome;
        logic              error_found;
        logic              position_out_of_range;
    } hec_rsp_t;

    // Decoded configuration seen by the coder
    typedef struct packed {
        logic [SYN_W-1:0]  n;
        logic [CODE_W-1:0] mask;
    } hec_cfg_t;

    // Least p with 2^p >= d + p + 1
    function automatic logic [3:0] parity_count(input logic [CFG_W:0] d);
        int pc;
        pc = 0;
        for (int k = 0; k < 8; k++) begin
            if ((1 << pc) < int'(d) + pc + 1) begin
                pc = pc + 1;
            end
        end
        return 4'(pc);
    endfunction

    // Largest data count whose codeword fits in maxcode bits
    function automatic int max_data(input int maxcode);
        int d;
        d = 1;
        for (int k = 1; k < 64; k++) begin
            if (k + int'(parity_count(7'(k))) <= maxcode) begin
                d = k;
            end
        end
        return d;
    endfunction

    // Ones in the low n bit places
    function automatic logic [CODE_W-1:0] code_mask(input logic [SYN_W-1:0] n);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int j = 0; j < CODE_W; j++) begin
            m[j] = (j < int'(n));
        end
        return m;
    endfunction

    function automatic bit is_pow2(input int pos);
        return (pos & (pos - 1)) == 0;
    endfunction

    // Data bit carried by a non-power-of-two position
    function automatic int data_index(input int pos);
        int lg;
        lg = 0;
        for (int k = 0; k < 8; k++) begin
            if ((pos >> (k + 1)) != 0) begin
                lg = k + 1;
            end
        end
        return pos - 2 - lg;
    endfunction

    // Positions whose index has bit b set
    function automatic logic [CODE_W-1:0] pos_bits(input int b);
        logic [CODE_W-1:0] m;
        m = '0;
        for (int j = 0; j < CODE_W; j++) begin
            m[j] = (((j + 1) >> b) & 1) != 0;
        end
        return m;
    endfunction

endpackage

@@ src/hec_cfg.sv @@
module hec_cfg #(
    parameter int MAX_CODE_BITS = hec_pkg::MAX_CODE_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [hec_pkg::CFG_W-1:0] cfg_data,
    output hec_pkg::hec_cfg_t         cfg
);
    import hec_pkg::*;

    localparam int              DMAX    = max_data(MAX_CODE_BITS);
    localparam int              RST_D   = (DATA_BITS_RESET > DMAX) ? DMAX : DATA_BITS_RESET;
    localparam logic [SYN_W-1:0] RST_N  = SYN_W'(RST_D + int'(parity_count(7'(RST_D))));

    logic [CFG_W-1:0] d_eff;
    logic [3:0]       p_cnt;
    hec_cfg_t         cfg_reg;
    hec_cfg_t         cfg_next;

    // Clamp the data count to the supported range
    always_comb
    begin
        d_eff = cfg_data;
        if (cfg_data == '0) begin
            d_eff = CFG_W'(1);
        end else if (cfg_data > CFG_W'(DMAX)) begin
            d_eff = CFG_W'(DMAX);
        end
    end

    // Derive codeword length and mask
    always_comb
    begin
        p_cnt         = parity_count({1'b0, d_eff});
        cfg_next.n    = d_eff + {2'b00, p_cnt};
        cfg_next.mask = code_mask(cfg_next.n);
    end

    // Hold decoded settings, load on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.n    <= RST_N;
            cfg_reg.mask <= code_mask(RST_N);
        end else if (cfg_valid && cfg_ready) begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

@@ src/hec_coder.sv @@
module hec_coder (
    input  hec_pkg::hec_req_t req,
    input  hec_pkg::hec_cfg_t cfg,
    output hec_pkg::hec_rsp_t rsp
);
    import hec_pkg::*;

    logic [CODE_W-1:0] placed;
    logic [CODE_W-1:0] masked;
    logic [CODE_W-1:0] par_vec;
    logic [CODE_W-1:0] flip_vec;
    logic [SYN_W-1:0]  syn;
    logic              err;
    logic              oor;

    // Spread data bits over the non-power-of-two positions
    for (genvar j = 0; j < CODE_W; j++) begin : g_place
        if (is_pow2(j + 1)) begin : g_par
            assign placed[j] = 1'b0;
        end else begin : g_dat
            assign placed[j] = req.data_word[data_index(j + 1)];
        end
    end

    // Select the check word or the placed data and drop bits beyond the codeword
    assign masked = (req.mode ? req.code_word : placed) & cfg.mask;

    // XOR of the positions of all set bits
    for (genvar b = 0; b < SYN_W; b++) begin : g_syn
        assign syn[b] = ^(masked & pos_bits(b));
    end

    // Place parity bits at the power-of-two positions
    always_comb
    begin
        par_vec = '0;
        for (int i = 0; i < SYN_W; i++) begin
            par_vec[(1 << i) - 1] = syn[i];
        end
    end

    // Decode the flip position
    for (genvar j = 0; j < CODE_W; j++) begin : g_flip
        assign flip_vec[j] = (syn == SYN_W'(j + 1));
    end

    assign err = (syn != '0);
    assign oor = (syn > cfg.n);

    // Assemble the result
    always_comb
    begin
        if (req.mode) begin
            rsp.code_out              = (err && !oor) ? (masked ^ flip_vec) : masked;
            rsp.syndrome              = syn;
            rsp.error_found           = err;
            rsp.position_out_of_range = oor;
        end else begin
            rsp.code_out              = (masked | par_vec) & cfg.mask;
            rsp.syndrome              = '0;
            rsp.error_found           = 1'b0;
            rsp.position_out_of_range = 1'b0;
        end
    end

endmodule

@@ src/hamming_encode_check_unit.sv @@
// Hamming single-error-correcting encoder and checker.
// Path: input register, one XOR-tree coder pass, then result register.
// Throughput: 1 item per cycle while rsp_stall is low; a stalled result holds the items back.
// Reset: asynchronous active low; clears both valid flags and sets the data count to 4.
`include "hamming_encode_check_unit_defines.svh"

module hamming_encode_check_unit #(
    parameter int MAX_CODE_BITS = hec_pkg::MAX_CODE_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [hec_pkg::CFG_W-1:0] cfg_data,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  hec_pkg::hec_req_t         req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output hec_pkg::hec_rsp_t         rsp
);
    import hec_pkg::*;

    hec_cfg_t cfg;
    hec_req_t s1_reg;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    hec_rsp_t out_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    hec_rsp_t coder_rsp;
    logic     out_move;
    logic     in_take;

    hec_cfg #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hec_coder u_coder (
        .req (s1_reg),
        .cfg (cfg),
        .rsp (coder_rsp)
    );

    // Advance when the result register is free or being taken
    assign out_move  = !out_valid_reg || !rsp_stall;
    assign req_stall = s1_valid_reg && !out_move;
    assign in_take   = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take) begin
            s1_valid_next = 1'b1;
        end else if (out_move) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_move ? s1_valid_reg : out_valid_reg;
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input item and result
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            s1_reg <= req;
        end
        if (out_move && s1_valid_reg) begin
            out_reg <= coder_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `HEC_ASSERT_IMP(a_oor_err, rsp_valid && rsp.position_out_of_range, rsp.error_found, "out of range without error")
    `HEC_ASSERT_IMP(a_err_syn, rsp_valid && rsp.error_found, rsp.syndrome != '0, "error with zero syndrome")
    `HEC_ASSERT_IMP(a_mask, rsp_valid, (rsp.code_out & ~cfg.mask) == '0, "codeword bits beyond length")
    `HEC_ASSERT_NXT(a_hold, s1_valid_reg && out_valid_reg && rsp_stall, s1_valid_reg && out_valid_reg, "item lost under stall")

endmodule

@@ tb/sv/hamming_encode_check_unit_tb.sv @@
`timescale 1ns / 100ps

module hamming_encode_check_unit_tb;

    import hec_pkg::*;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;
    localparam int   MAX_REPORTS = 10;
    localparam int   DRAIN_CYCLES = 4;

    // Predict each coder result and compare it with what the block returns
    class hamming_checker;
        logic [CFG_W-1:0] data_count;
        hec_rsp_t         pending_words[$];
        int               mismatches;

        function new();
            data_count = CFG_W'(DATA_BITS_RESET);
            mismatches = 0;
        endfunction

        function void set_data_count(logic [CFG_W-1:0] value);
            data_count = value;
        endfunction

        function int parity_bits(int d);
            int p;
            p = 0;
            while (p < 8 && (1 << p) < d + p + 1) p++;
            return p;
        endfunction

        // Codeword length after clamping the data count to what fits
        function int code_len();
            int d;
            d = int'(data_count);
            if (d < 1) d = 1;
            while (d > 1 && d + parity_bits(d) > MAX_CODE_BITS_DEFAULT) d--;
            return d + parity_bits(d);
        endfunction

        function int word_syndrome(logic [CODE_W-1:0] word, int n);
            int s;
            s = 0;
            for (int pos = 1; pos <= n; pos++) begin
                if (word[pos-1]) s = s ^ pos;
            end
            return s;
        endfunction

        function hec_rsp_t predict(hec_req_t item);
            hec_rsp_t          r;
            logic [CODE_W-1:0] mask;
            int                n;
            int                di;
            int                syn;
            n = code_len();
            mask = (CODE_W'(1) << n) - CODE_W'(1);
            r = '0;
            if (item.mode == MODE_ENCODE) begin
                // scatter data over the non-power-of-two positions
                di = 0;
                for (int pos = 1; pos <= n; pos++) begin
                    if ((pos & (pos - 1)) != 0) begin
                        if (item.data_word[di]) r.code_out[pos-1] = 1'b1;
                        di++;
                    end
                end
                // parity slots are still zero, so the syndrome gives the parity bits
                syn = word_syndrome(r.code_out, n);
                for (int pos = 1; pos <= n; pos = pos * 2) begin
                    if ((syn & pos) != 0) r.code_out[pos-1] = 1'b1;
                end
            end else begin
                r.code_out = item.code_word & mask;
                syn = word_syndrome(r.code_out, n);
                r.syndrome = SYN_W'(syn);
                if (syn != 0) begin
                    r.error_found = 1'b1;
                    if (syn > n) r.position_out_of_range = 1'b1;
                    else r.code_out[syn-1] = ~r.code_out[syn-1];
                end
            end
            r.code_out = r.code_out & mask;
            return r;
        endfunction

        function void note_item(hec_req_t item);
            pending_words.push_back(predict(item));
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void check_result(hec_rsp_t got);
            hec_rsp_t want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing pending: code %h syn %0d err %b oor %b",
                             got.code_out, got.syndrome, got.error_found,
                             got.position_out_of_range);
                return;
            end
            want = pending_words.pop_front();
            if (got.code_out !== want.code_out || got.syndrome !== want.syndrome ||
                got.error_found !== want.error_found ||
                got.position_out_of_range !== want.position_out_of_range) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch at %0t: got code %h syn %0d err %b oor %b, want code %h syn %0d err %b oor %b",
                             $time, got.code_out, got.syndrome, got.error_found,
                             got.position_out_of_range, want.code_out, want.syndrome,
                             want.error_found, want.position_out_of_range);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             req_valid;
    logic             req_stall;
    hec_req_t         req;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    hec_rsp_t         rsp;

    hamming_checker board = new();
    int             idle_pct = 0;
    int             stall_pct = 0;

    hamming_encode_check_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    // Stall the result side at random
    always @(negedge clk)
    begin
        rsp_stall <= rst_n && ($urandom_range(99, 0) < stall_pct);
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall) board.check_result(rsp);
    end

    function automatic hec_req_t make_item(logic mode, logic [DATA_W-1:0] data,
                                           logic [CODE_W-1:0] code);
        hec_req_t it;
        it.mode = mode;
        it.data_word = data;
        it.code_word = code;
        return it;
    endfunction

    function automatic logic [CODE_W-1:0] encoded(logic [DATA_W-1:0] data);
        return board.predict(make_item(MODE_ENCODE, data, '0)).code_out;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random mode; check items are mostly valid codewords with zero, one or two flips, some pure noise
    function automatic hec_req_t random_item();
        hec_req_t          it;
        logic [CODE_W-1:0] cw;
        logic [CODE_W-1:0] mask;
        int                n;
        int                kind;
        it = make_item(1'($urandom_range(1, 0)), DATA_W'(rand64()), CODE_W'(rand64()));
        if (it.mode == MODE_CHECK) begin
            kind = $urandom_range(9, 0);
            if (kind < 7) begin
                n = board.code_len();
                mask = (CODE_W'(1) << n) - CODE_W'(1);
                cw = encoded(DATA_W'(rand64()));
                if (kind >= 3) cw[$urandom_range(n - 1, 0)] ^= 1'b1;
                if (kind == 6) cw[$urandom_range(n - 1, 0)] ^= 1'b1;
                // junk above the codeword must be ignored
                if ($urandom_range(1, 0) == 1) cw = cw | (CODE_W'(rand64()) & ~mask);
                it.code_word = cw;
            end
        end
        return it;
    endfunction

    task automatic send_item(input hec_req_t item);
        @(negedge clk);
        while ($urandom_range(99, 0) < idle_pct) begin
            req_valid = 1'b0;
            req = make_item(1'($urandom_range(1, 0)), DATA_W'(rand64()), CODE_W'(rand64()));
            @(negedge clk);
        end
        req_valid = 1'b1;
        req = item;
        do @(posedge clk); while (req_stall);
        board.note_item(item);
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic wait_idle();
        @(negedge clk);
        req_valid = 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_data_count(input logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        board.set_data_count(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic directed_items();
        logic [CODE_W-1:0] cw;
        // reset count of four data bits, seven-bit codeword
        send_item(make_item(MODE_ENCODE, '0, '0));
        send_item(make_item(MODE_ENCODE, '1, '0));
        send_item(make_item(MODE_ENCODE, DATA_W'(5), '0));
        cw = encoded(DATA_W'('hA));
        send_item(make_item(MODE_CHECK, '0, cw));
        send_item(make_item(MODE_CHECK, '0, cw ^ CODE_W'(1)));
        send_item(make_item(MODE_CHECK, '0, cw ^ CODE_W'('h40)));
        send_item(make_item(MODE_CHECK, '0, cw ^ CODE_W'(3)));
        send_item(make_item(MODE_CHECK, '1, '1));
        send_item(make_item(MODE_CHECK, '1, '0));
        // full-width codeword
        write_data_count(CFG_W'(57));
        send_item(make_item(MODE_ENCODE, '1, '0));
        send_item(make_item(MODE_ENCODE, '0, '1));
        send_item(make_item(MODE_CHECK, '0, '1));
        cw = encoded(DATA_W'(rand64()));
        send_item(make_item(MODE_CHECK, '0, cw ^ (CODE_W'(1) << 62)));
        send_item(make_item(MODE_CHECK, '0, cw ^ (CODE_W'(1) << 31)));
        // five-bit codeword: syndrome six lies past the end
        write_data_count(CFG_W'(2));
        send_item(make_item(MODE_CHECK, '0, CODE_W'('b01010)));
        send_item(make_item(MODE_CHECK, '0, '1));
        // zero count acts as one data bit
        write_data_count('0);
        send_item(make_item(MODE_ENCODE, '1, '0));
        send_item(make_item(MODE_CHECK, '0, '1));
        // oversized count saturates
        write_data_count('1);
        send_item(make_item(MODE_ENCODE, '1, '0));
        send_item(make_item(MODE_CHECK, '0, CODE_W'(rand64())));
    endtask

    // Give up on a hung run
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] settings[$];
        settings = '{CFG_W'(1), CFG_W'(2), CFG_W'(3), CFG_W'(57), CFG_W'(63), CFG_W'(0),
                     CFG_W'(5), CFG_W'(11), CFG_W'(26), CFG_W'(58), CFG_W'(4),
                     CFG_W'(31), CFG_W'(32)};
        settings.push_back(CFG_W'($urandom_range(63, 0)));
        settings.push_back(CFG_W'($urandom_range(63, 0)));
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_items();

        // cycle through no idling, sender gaps, receiver stalls, both
        foreach (settings[k])
        begin
            write_data_count(settings[k]);
            case (k % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            repeat (44) send_item(random_item());
        end

        wait_idle();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/hec_pkg.sv
src/hec_cfg.sv
src/hec_coder.sv
src/hamming_encode_check_unit.sv
tb/sv/hamming_encode_check_unit_tb.sv
